>>> sv/pfm_pkg.sv
// ============================================================================
// pfm_pkg
// Shared constants and controller/datapath interface types for the piece to
// file segment mapper.
// ============================================================================
package pfm_pkg;

    localparam int MAX_FILES_DEF  = 16;

    localparam int LEN_W          = 40;   // file length and file offset
    localparam int PSZ_W          = 25;   // piece size and segment length
    localparam int POFF_W         = 24;   // offset inside a piece
    localparam int PIDX_W         = 20;   // piece index
    localparam int FIDX_W         = 4;    // file index on the result
    localparam int FCNT_W         = 5;    // file_count register
    localparam int LIN_W          = PIDX_W + PSZ_W;

    localparam logic [PSZ_W-1:0]  PSZ_RESET = 25'd262144;
    localparam logic [PSZ_W-1:0]  PSZ_LIMIT = 25'd16777216;

    localparam logic              ACT_LOAD  = 1'b0;
    localparam logic              ACT_MAP   = 1'b1;

    localparam logic              REG_PIECE_SIZE = 1'b0;
    localparam logic              REG_FILE_COUNT = 1'b1;

    localparam logic [1:0]        ST_OK     = 2'd0;
    localparam logic [1:0]        ST_BEYOND = 2'd1;
    localparam logic [1:0]        ST_SHORT  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       map_init;
        logic       mul;
        logic       rd_en;
        logic       rd_next;
        logic       srch_next;
        logic       srch_hit;
        logic       err;
        logic       seg;
        logic       fin;
        logic [1:0] fin_status;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic found;
        logic psz_zero;
        logic seg_done;
        logic files_end;
    } t_sts;

endpackage

>>> sv/pfm_ctrl.sv
// ============================================================================
// pfm_ctrl
// Sequencer for the mapper: load, multiply, table search, segment walk and
// final result.
// ============================================================================
module pfm_ctrl
    import pfm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_action,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SEV  = 3'd3;
    localparam logic [2:0] S_SEG  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_fin_st, n_fin_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin_st <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_fin_st <= n_fin_st;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fin_st = r_fin_st;
        o_cmd    = '0;
        o_cmd.fin_status = r_fin_st;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_MAP) begin
                        o_cmd.map_init = 1'b1;
                        n_state        = S_MUL;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SRD;
            end
            S_SRD: begin
                if (i_sts.idx_end) begin
                    o_cmd.err = 1'b1;
                    n_fin_st  = ST_BEYOND;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SEV;
                end
            end
            S_SEV: begin
                if (i_sts.found) begin
                    o_cmd.srch_hit = 1'b1;
                    if (i_sts.psz_zero) begin
                        n_fin_st = ST_OK;
                        n_state  = S_FIN;
                    end else begin
                        n_state  = S_SEG;
                    end
                end else begin
                    o_cmd.srch_next = 1'b1;
                    n_state         = S_SRD;
                end
            end
            S_SEG: begin
                // The next table entry is fetched while this segment is cut.
                o_cmd.seg     = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_next = 1'b1;
                if (i_sts.seg_done) begin
                    n_fin_st = ST_OK;
                    n_state  = S_FIN;
                end else if (i_sts.files_end) begin
                    n_fin_st = ST_SHORT;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> sv/pfm_dpath.sv
// ============================================================================
// pfm_dpath
// File length table, piece multiplier, prefix sum search and segment
// arithmetic, with a one-deep hold for the segment not yet known to be last.
// ============================================================================
module pfm_dpath
    import pfm_pkg::*;
#(
    parameter int MAX_FILES = MAX_FILES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [PSZ_W-1:0]  i_piece_size,
    input  logic [FCNT_W-1:0] i_file_count,
    input  logic [3:0]        i_file_slot,
    input  logic [LEN_W-1:0]  i_file_length,
    input  logic [PIDX_W-1:0] i_piece_index,
    output logic              o_strobe,
    output logic [FIDX_W-1:0] o_file_index,
    output logic [LEN_W-1:0]  o_file_offset,
    output logic [POFF_W-1:0] o_segment_piece_offset,
    output logic [PSZ_W-1:0]  o_segment_length,
    output logic              o_last,
    output logic [1:0]        o_status
);

    localparam int IDX_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int CNT_W = $clog2(MAX_FILES + 1);
    localparam int END_W = LIN_W + CNT_W;

    logic [LEN_W-1:0]  mem [MAX_FILES];
    logic [LEN_W-1:0]  r_rd;

    logic [PIDX_W-1:0] r_pi;
    logic [PSZ_W-1:0]  r_psz;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [LIN_W-1:0]  r_lin;
    logic [END_W-1:0]  r_end;
    logic [LEN_W-1:0]  r_foff;
    logic [PSZ_W-1:0]  r_rem;
    logic [PSZ_W-1:0]  r_poff;

    logic              r_pv;
    logic [FIDX_W-1:0] r_p_fi;
    logic [LEN_W-1:0]  r_p_fo;
    logic [POFF_W-1:0] r_p_po;
    logic [PSZ_W-1:0]  r_p_len;

    logic              r_o_strobe;
    logic [FIDX_W-1:0] r_o_fi;
    logic [LEN_W-1:0]  r_o_fo;
    logic [POFF_W-1:0] r_o_po;
    logic [PSZ_W-1:0]  r_o_len;
    logic              r_o_last;
    logic [1:0]        r_o_st;

    logic [PSZ_W-1:0]  n_psz;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W:0]    n_idx_inc;
    logic [IDX_W-1:0]  n_rd_addr;
    logic [END_W-1:0]  n_end;
    logic [END_W-1:0]  n_diff;
    logic [LEN_W-1:0]  n_avail;
    logic [PSZ_W-1:0]  n_len;
    logic              n_emit_prev;

    assign n_psz   = (i_piece_size > PSZ_LIMIT) ? PSZ_LIMIT : i_piece_size;
    assign n_count = (32'(i_file_count) > MAX_FILES) ? CNT_W'(MAX_FILES)
                                                    : CNT_W'(i_file_count);

    assign n_idx_inc = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign n_rd_addr = i_cmd.rd_next ? IDX_W'(n_idx_inc) : IDX_W'(r_idx);

    // Running end of the table up to and including the entry just read.
    assign n_end  = r_end + END_W'(r_rd);
    assign n_diff = END_W'(r_lin) - r_end;

    assign n_avail = r_rd - r_foff;
    assign n_len   = ({{(LEN_W-PSZ_W){1'b0}}, r_rem} < n_avail) ? r_rem
                                                               : PSZ_W'(n_avail);
    assign n_emit_prev = i_cmd.seg && (n_len != '0) && r_pv;

    assign o_sts.idx_end   = (r_idx >= r_count);
    assign o_sts.found     = (END_W'(r_lin) < n_end);
    assign o_sts.psz_zero  = (r_psz == '0);
    assign o_sts.seg_done  = (n_len == r_rem);
    assign o_sts.files_end = (n_idx_inc >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_file_slot) < MAX_FILES)) begin
            mem[IDX_W'(i_file_slot)] <= i_file_length;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[n_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_init) begin
            r_pi    <= i_piece_index;
            r_psz   <= n_psz;
            r_count <= n_count;
            r_idx   <= '0;
            r_end   <= '0;
        end
        if (i_cmd.mul) begin
            r_lin <= LIN_W'(r_pi) * LIN_W'(r_psz);
        end
        if (i_cmd.srch_next) begin
            r_end <= n_end;
            r_idx <= CNT_W'(n_idx_inc);
        end
        if (i_cmd.srch_hit) begin
            r_foff  <= n_diff[LEN_W-1:0];
            r_rem   <= r_psz;
            r_poff  <= '0;
            r_p_fi  <= FIDX_W'(r_idx);
            r_p_fo  <= n_diff[LEN_W-1:0];
            r_p_po  <= '0;
            r_p_len <= '0;
        end
        if (i_cmd.err) begin
            r_p_fi  <= '0;
            r_p_fo  <= '0;
            r_p_po  <= '0;
            r_p_len <= '0;
        end
        if (i_cmd.seg) begin
            if (n_len != '0) begin
                r_p_fi  <= FIDX_W'(r_idx);
                r_p_fo  <= r_foff;
                r_p_po  <= r_poff[POFF_W-1:0];
                r_p_len <= n_len;
            end
            r_rem  <= r_rem - n_len;
            r_poff <= r_poff + n_len;
            r_idx  <= CNT_W'(n_idx_inc);
            r_foff <= '0;
        end
        if (n_emit_prev || i_cmd.fin) begin
            r_o_fi   <= r_p_fi;
            r_o_fo   <= r_p_fo;
            r_o_po   <= r_p_po;
            r_o_len  <= r_p_len;
            r_o_last <= i_cmd.fin;
            r_o_st   <= i_cmd.fin ? i_cmd.fin_status : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv       <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= n_emit_prev || i_cmd.fin;
            if (i_cmd.map_init) begin
                r_pv <= 1'b0;
            end else if (i_cmd.seg && (n_len != '0)) begin
                r_pv <= 1'b1;
            end
        end
    end

    assign o_strobe               = r_o_strobe;
    assign o_file_index           = r_o_fi;
    assign o_file_offset          = r_o_fo;
    assign o_segment_piece_offset = r_o_po;
    assign o_segment_length       = r_o_len;
    assign o_last                 = r_o_last;
    assign o_status               = r_o_st;

endmodule

>>> sv/piece_to_file_segment_mapper.sv
// ============================================================================
// piece_to_file_segment_mapper
// Maps a piece index onto the files of a table of file lengths and emits one
// segment result per non-empty file the piece crosses, or one result if none.
// ============================================================================
//  Channel   Direction  Handshake                       Payload
//  ------    ---------  ------------------------------  ---------------------
//  command   in         start && !busy                  action, slot, length,
//                                                       piece index
//  result    out        o_strobe, one cycle, no stall   segment fields, status
//  config    in         psel && penable && pwrite       piece size, file count
//
//  A load item is written in the idle state and busy stays low. A map item
//  runs capture and multiply, a table read and a prefix compare for each
//  table entry searched, a segment walk over the files it crosses, and then
//  delivery of the final result. The walk starts on the file the search
//  found. A result strobe may appear in the cycle after busy falls; a new
//  item can be accepted in that cycle. Reset is synchronous and active low;
//  the file table is not cleared. The receiver cannot stall the results.
// ============================================================================
module piece_to_file_segment_mapper
    import pfm_pkg::*;
#(
    parameter int MAX_FILES = MAX_FILES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [3:0]        i_file_slot,
    input  logic [LEN_W-1:0]  i_file_length,
    input  logic [PIDX_W-1:0] i_piece_index,
    output logic              o_strobe,
    output logic [FIDX_W-1:0] o_file_index,
    output logic [LEN_W-1:0]  o_file_offset,
    output logic [POFF_W-1:0] o_segment_piece_offset,
    output logic [PSZ_W-1:0]  o_segment_length,
    output logic              o_last,
    output logic [1:0]        o_status
);

    logic [PSZ_W-1:0]  r_piece_size;
    logic [FCNT_W-1:0] r_file_count;
    logic              n_cfg_wr;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piece_size <= PSZ_RESET;
            r_file_count <= '0;
        end else if (n_cfg_wr) begin
            case (paddr[2])
                REG_PIECE_SIZE: r_piece_size <= pwdata[PSZ_W-1:0];
                REG_FILE_COUNT: r_file_count <= pwdata[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PIECE_SIZE: prdata = {{(32-PSZ_W){1'b0}}, r_piece_size};
            REG_FILE_COUNT: prdata = {{(32-FCNT_W){1'b0}}, r_file_count};
            default:        prdata = '0;
        endcase
    end

    pfm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    pfm_dpath #(
        .MAX_FILES (MAX_FILES)
    ) u_dpath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_sts                  (w_sts),
        .i_piece_size           (r_piece_size),
        .i_file_count           (r_file_count),
        .i_file_slot            (i_file_slot),
        .i_file_length          (i_file_length),
        .i_piece_index          (i_piece_index),
        .o_strobe               (o_strobe),
        .o_file_index           (o_file_index),
        .o_file_offset          (o_file_offset),
        .o_segment_piece_offset (o_segment_piece_offset),
        .o_segment_length       (o_segment_length),
        .o_last                 (o_last),
        .o_status               (o_status)
    );

endmodule

>>> sv/pfm_chk.sv
// ============================================================================
// pfm_chk
// Port-level checks on the mapper's command and result behaviour.
// ============================================================================
module pfm_chk
    import pfm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_action,
    input logic              o_strobe,
    input logic [PSZ_W-1:0]  o_segment_length,
    input logic              o_last,
    input logic [1:0]        o_status
);

    // Reset leaves the block idle with no result on the ports.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not idle after reset");

    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_action == ACT_MAP) |=> busy)
        else $error("map item did not start work");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_action == ACT_LOAD) |=> !busy && !o_strobe)
        else $error("load item caused work or a result");

    // Further results of the same item must still be in progress.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result while idle");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |->
            o_last && ((o_status != ST_BEYOND) || (o_segment_length == '0)))
        else $error("bad status on result");

endmodule

bind piece_to_file_segment_mapper pfm_chk u_pfm_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_action         (i_action),
    .o_strobe         (o_strobe),
    .o_segment_length (o_segment_length),
    .o_last           (o_last),
    .o_status         (o_status)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking testbench for the piece to file segment mapper. A directed
// table of load, map and register items comes first, followed by random
// phases under several piece sizes and file counts. Every result is checked
// field by field, in arrival order, against a file walk predictor or a typed result.
// ============================================================================
module tb;
    import pfm_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         SETTLE_CYCLES   = 64;
    localparam logic [2:0] ADDR_PIECE_SIZE = {REG_PIECE_SIZE, 2'b00};
    localparam logic [2:0] ADDR_FILE_COUNT = {REG_FILE_COUNT, 2'b00};
    localparam int         NUM_PHASES      = 9;

    typedef struct packed {
        logic [FIDX_W-1:0] file_index;
        logic [LEN_W-1:0]  file_off;
        logic [POFF_W-1:0] piece_off;
        logic [PSZ_W-1:0]  seg_len;
        logic              last;
        logic [1:0]        status;
    } t_seg;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_MAP} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [2:0]        addr;
        logic [31:0]       wdata;
        logic [3:0]        slot;
        logic [LEN_W-1:0]  flen;
        logic [PIDX_W-1:0] pidx;
        bit                typed;
        t_seg              res;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic              i_action;
    logic [3:0]        i_file_slot;
    logic [LEN_W-1:0]  i_file_length;
    logic [PIDX_W-1:0] i_piece_index;
    logic              o_strobe;
    logic [FIDX_W-1:0] o_file_index;
    logic [LEN_W-1:0]  o_file_offset;
    logic [POFF_W-1:0] o_segment_piece_offset;
    logic [PSZ_W-1:0]  o_segment_length;
    logic              o_last;
    logic [1:0]        o_status;

    // Predictor state: the file table and both registers as the block holds them.
    logic [LEN_W-1:0]  file_len_tbl [MAX_FILES_DEF];
    logic [PSZ_W-1:0]  cfg_piece_size;
    logic [FCNT_W-1:0] cfg_file_count;
    t_seg              seg_expect [$];
    int                err_count    = 0;
    int                burst_left   = 0;
    int                quiet_cycles = 0;

    logic [31:0] phase_psz   [NUM_PHASES] = '{32'd262144, 32'd1, 32'd4096, 32'd0,
                                              32'hFFFF_FFFF, 32'd1000, 32'd777,
                                              32'd65536, 32'd16777216};
    logic [31:0] phase_count [NUM_PHASES] = '{32'd16, 32'd16, 32'd5, 32'd16,
                                              32'hFFFF_FFFF, 32'd1, 32'd0,
                                              32'd16, 32'd9};
    int          phase_items [NUM_PHASES] = '{40, 30, 35, 15, 30, 25, 15, 40, 25};

    piece_to_file_segment_mapper uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .start                  (start),
        .busy                   (busy),
        .i_action               (i_action),
        .i_file_slot            (i_file_slot),
        .i_file_length          (i_file_length),
        .i_piece_index          (i_piece_index),
        .o_strobe               (o_strobe),
        .o_file_index           (o_file_index),
        .o_file_offset          (o_file_offset),
        .o_segment_piece_offset (o_segment_piece_offset),
        .o_segment_length       (o_segment_length),
        .o_last                 (o_last),
        .o_status               (o_status)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_seg mk_seg(input logic [63:0] fi, input logic [63:0] fo,
                                    input logic [63:0] po, input logic [63:0] len,
                                    input logic last, input logic [1:0] st);
        t_seg r;
        r.file_index  = fi[FIDX_W-1:0];
        r.file_off    = fo[LEN_W-1:0];
        r.piece_off   = po[POFF_W-1:0];
        r.seg_len     = len[PSZ_W-1:0];
        r.last        = last;
        r.status      = st;
        return r;
    endfunction

    function automatic logic [63:0] eff_piece_size();
        return (cfg_piece_size > PSZ_LIMIT) ? 64'(PSZ_LIMIT) : 64'(cfg_piece_size);
    endfunction

    function automatic int eff_file_count();
        return (cfg_file_count > MAX_FILES_DEF) ? MAX_FILES_DEF : int'(cfg_file_count);
    endfunction

    // Works out the segments of one map item and queues them in order.
    function automatic void predict_segments(input logic [PIDX_W-1:0] idx);
        logic [63:0] psz, lin, run_end, foff, rem, poff, avail, len;
        int          cnt, f;
        t_seg        segs [$];
        t_seg        r;
        psz = eff_piece_size();
        cnt = eff_file_count();
        lin = 64'(idx) * psz;
        run_end = 0;
        for (f = 0; f < cnt; f++) begin
            run_end += 64'(file_len_tbl[f]);
            if (lin < run_end) break;
        end
        if (f >= cnt) begin
            seg_expect.push_back(mk_seg(0, 0, 0, 0, 1'b1, ST_BEYOND));
            return;
        end
        foff = lin - (run_end - 64'(file_len_tbl[f]));
        rem  = psz;
        poff = 0;
        if (rem == 0) begin
            seg_expect.push_back(mk_seg(f, foff, 0, 0, 1'b1, ST_OK));
            return;
        end
        forever begin
            avail = 64'(file_len_tbl[f]) - foff;
            len   = (rem < avail) ? rem : avail;
            // Empty files along the way give no segment at all.
            if (len != 0) begin
                segs.push_back(mk_seg(f, foff, poff, len, 1'b0, ST_OK));
                poff += len;
                rem  -= len;
            end
            if (rem == 0) break;
            f++;
            if (f >= cnt) begin
                r = segs.pop_back();
                r.status = ST_SHORT;
                segs.push_back(r);
                break;
            end
            foff = 0;
        end
        r = segs.pop_back();
        r.last = 1'b1;
        segs.push_back(r);
        foreach (segs[k]) seg_expect.push_back(segs[k]);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        logic [63:0] unit, wide;
        unit = eff_piece_size();
        if (unit == 0) unit = 4096;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(9, 0))
            0, 1:    return '0;
            2, 3, 4: return LEN_W'($urandom_range(3 * unit[31:0], 1));
            5, 6:    return LEN_W'(unit * $urandom_range(3, 1));
            7:       return wide[LEN_W-1:0];
            default: return wide[LEN_W-1:0] >> $urandom_range(39, 8);
        endcase
    endfunction

    function automatic logic [PIDX_W-1:0] pick_index();
        logic [63:0] psz, total, hi, pe;
        int          cnt, k, j;
        psz = eff_piece_size();
        cnt = eff_file_count();
        total = 0;
        for (k = 0; k < cnt; k++) total += 64'(file_len_tbl[k]);
        if (psz != 0 && cnt != 0) begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3, 4, 5: begin
                    hi = total / psz;
                    if (hi > 64'hF_FFFF) hi = 64'hF_FFFF;
                    return PIDX_W'($urandom_range(hi[31:0], 0));
                end
                6, 7: begin
                    // Land exactly on the end of a file, which belongs to the next one.
                    k  = $urandom_range(cnt - 1, 0);
                    pe = 0;
                    for (j = 0; j <= k; j++) pe += 64'(file_len_tbl[j]);
                    if (pe % psz == 0 && pe / psz <= 64'hF_FFFF) return PIDX_W'(pe / psz);
                end
                default: ;
            endcase
        end
        return PIDX_W'($urandom_range(32'hF_FFFF, 0));
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    function automatic t_step mk_cfg(input logic [2:0] addr, input logic [31:0] data);
        t_step s;
        s = '{kind: ROW_CFG, addr: addr, wdata: data, slot: '0, flen: '0, pidx: '0,
              typed: 1'b0, res: '0};
        return s;
    endfunction

    function automatic t_step mk_load(input logic [3:0] slot, input logic [LEN_W-1:0] flen);
        t_step s;
        s = '{kind: ROW_LOAD, addr: '0, wdata: '0, slot: slot, flen: flen,
              pidx: PIDX_W'($urandom()), typed: 1'b0, res: '0};
        return s;
    endfunction

    function automatic t_step mk_map(input logic [PIDX_W-1:0] idx, input bit typed,
                                     input t_seg res);
        t_step s;
        s = '{kind: ROW_MAP, addr: '0, wdata: '0, slot: 4'($urandom()),
              flen: LEN_W'({$urandom(), $urandom()}), pidx: idx, typed: typed, res: res};
        return s;
    endfunction

    task automatic send_item(input logic action, input logic [3:0] slot,
                             input logic [LEN_W-1:0] flen, input logic [PIDX_W-1:0] pidx,
                             input bit typed, input t_seg res);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20)
                                                     : $urandom_range(8, 1);
            gap = $urandom_range(6, 1);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= action;
        i_file_slot   <= slot;
        i_file_length <= flen;
        i_piece_index <= pidx;
        do begin
            @(posedge i_clk);
        end while (busy);
        burst_left--;
        if (action == ACT_LOAD)
            file_len_tbl[slot] = flen;
        else if (typed)
            seg_expect.push_back(res);
        else
            predict_segments(pidx);
    endtask

    // A load gives no result; after the queue empties, settle leaves time to finish.
    task automatic drain(input bit settle);
        @(negedge i_clk);
        start <= 1'b0;
        while (seg_expect.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_register(input logic [2:0] addr, input logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0h expected %0h actual %0h", $time, addr, want, prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_PIECE_SIZE) begin
            cfg_piece_size = data[PSZ_W-1:0];
            read_register(addr, 32'(cfg_piece_size));
        end else begin
            cfg_file_count = data[FCNT_W-1:0];
            read_register(addr, 32'(cfg_file_count));
        end
    endtask

    always @(posedge i_clk) begin
        t_seg want;
        if (i_rst_n && o_strobe) begin
            if (seg_expect.size() == 0) begin
                $display("%0t: unexpected result, file %0h offset %0h length %0h status %0h",
                         $time, o_file_index, o_file_offset, o_segment_length, o_status);
                err_count++;
            end else begin
                want = seg_expect.pop_front();
                check_field("file_index", want.file_index, o_file_index);
                check_field("file offset", want.file_off, o_file_offset);
                check_field("segment_piece_offset", want.piece_off, o_segment_piece_offset);
                check_field("segment_length", want.seg_len, o_segment_length);
                check_field("last", want.last, o_last);
                check_field("status", want.status, o_status);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_step steps [$];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        start         = 1'b0;
        i_action      = ACT_LOAD;
        i_file_slot   = '0;
        i_file_length = '0;
        i_piece_index = '0;
        cfg_piece_size = PSZ_RESET;
        cfg_file_count = '0;
        foreach (file_len_tbl[k]) file_len_tbl[k] = '0;

        // With no files in use every map lands beyond the end.
        steps.push_back(mk_map(20'h0, 1'b1, mk_seg(0, 0, 0, 0, 1'b1, ST_BEYOND)));
        steps.push_back(mk_map(20'hF_FFFF, 1'b1, mk_seg(0, 0, 0, 0, 1'b1, ST_BEYOND)));
        steps.push_back(mk_load(4'd0, 40'd524288));
        steps.push_back(mk_load(4'd1, 40'd0));
        steps.push_back(mk_load(4'd2, 40'd100000));
        steps.push_back(mk_load(4'd3, 40'hFF_FFFF_FFFF));
        steps.push_back(mk_load(4'd4, 40'd1));
        steps.push_back(mk_load(4'd5, 40'd262144));
        steps.push_back(mk_load(4'd6, 40'd0));
        steps.push_back(mk_load(4'd7, 40'd7));
        steps.push_back(mk_load(4'd8, 40'd262143));
        steps.push_back(mk_load(4'd9, 40'd500000));
        steps.push_back(mk_load(4'd10, 40'h80_0000_0000));
        steps.push_back(mk_load(4'd11, 40'd1048576));
        steps.push_back(mk_load(4'd12, 40'd3));
        steps.push_back(mk_load(4'd13, 40'd0));
        steps.push_back(mk_load(4'd14, 40'd2));
        steps.push_back(mk_load(4'd15, 40'h12_3456_789A));
        steps.push_back(mk_cfg(ADDR_FILE_COUNT, 32'd4));
        steps.push_back(mk_map(20'd0, 1'b1, mk_seg(0, 0, 0, 262144, 1'b1, ST_OK)));
        steps.push_back(mk_map(20'd1, 1'b0, '0));
        // Starts on the end of file 0, skips the empty file 1 and crosses into file 3.
        steps.push_back(mk_map(20'd2, 1'b0, '0));
        steps.push_back(mk_cfg(ADDR_FILE_COUNT, 32'd3));
        steps.push_back(mk_map(20'd2, 1'b0, '0));
        steps.push_back(mk_cfg(ADDR_FILE_COUNT, 32'd2));
        steps.push_back(mk_map(20'd2, 1'b1, mk_seg(0, 0, 0, 0, 1'b1, ST_BEYOND)));
        steps.push_back(mk_cfg(ADDR_PIECE_SIZE, 32'd0));
        steps.push_back(mk_map(20'd5, 1'b1, mk_seg(0, 0, 0, 0, 1'b1, ST_OK)));
        // Oversized register values act as their limits.
        steps.push_back(mk_cfg(ADDR_PIECE_SIZE, 32'hFFFF_FFFF));
        steps.push_back(mk_cfg(ADDR_FILE_COUNT, 32'hFFFF_FFFF));
        steps.push_back(mk_map(20'd0, 1'b0, '0));
        steps.push_back(mk_map(20'hF_FFFF, 1'b0, '0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        read_register(ADDR_PIECE_SIZE, 32'(PSZ_RESET));
        read_register(ADDR_FILE_COUNT, 32'd0);

        foreach (steps[s]) begin
            case (steps[s].kind)
                ROW_CFG: begin
                    drain(1'b1);
                    write_register(steps[s].addr, steps[s].wdata);
                end
                ROW_LOAD: send_item(ACT_LOAD, steps[s].slot, steps[s].flen, steps[s].pidx,
                                    1'b0, '0);
                default:  send_item(ACT_MAP, steps[s].slot, steps[s].flen, steps[s].pidx,
                                    steps[s].typed, steps[s].res);
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain(1'b1);
            write_register(ADDR_PIECE_SIZE, phase_psz[p]);
            write_register(ADDR_FILE_COUNT, phase_count[p]);
            repeat (phase_items[p]) begin
                if ($urandom_range(24, 0) == 0) drain(1'b0);
                if ($urandom_range(3, 0) == 0)
                    send_item(ACT_LOAD, 4'($urandom()), pick_length(),
                              PIDX_W'($urandom()), 1'b0, '0);
                else
                    send_item(ACT_MAP, 4'($urandom()), LEN_W'({$urandom(), $urandom()}),
                              pick_index(), 1'b0, '0);
            end
        end

        drain(1'b1);
        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
